### design/bsr_pkg.sv
// Shared types, sizes and helpers for the byte stream reassembler.
// Has no dependencies; every other design file but bsr_ram imports it.
package bsr_pkg;

  // Field widths of the stream interface.
  localparam int IDX_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;

  // Reorder window size, legal range 2 to 64.
  localparam int WINDOW_BYTES = 64;
  localparam int SLOT_W       = $clog2(WINDOW_BYTES);
  localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);
  localparam int SUM_W        = SLOT_W + 1;

  // Input queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One input beat as it travels through the queue.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              eos;
  } item_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_SCAN,
    BK_EMIT
  } back_state_e;

  // Slot that lies ofs places after base in the circular window.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= SUM_W'(WINDOW_BYTES)) begin
      sum = sum - SUM_W'(WINDOW_BYTES);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

### design/bsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the new data. No dependencies.
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read with write-first bypass.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bsr_front.sv
// Front end: accepts input beats and holds them in a short queue.
// Depends on bsr_pkg for the item record and queue sizes.
module bsr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsr_pkg::item_t item_i,
  output logic          q_valid_o,
  output bsr_pkg::item_t q_item_o,
  input  logic          q_pop_i
);
  import bsr_pkg::*;

  item_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  fill_q, fill_d;
  logic               push;
  logic               pop;

  assign in_stall_o = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### design/bsr_back.sv
// Back end: window insert, end trimming, run length scan and in-order drain.
// Depends on bsr_pkg and instantiates bsr_ram for the window bytes.
module bsr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  bsr_pkg::item_t             q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bsr_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_o,
  output logic                       stream_ended_o,
  output logic [bsr_pkg::COUNT_W-1:0] unassembled_count_o
);
  import bsr_pkg::*;

  back_state_e             state_q, state_d;
  logic [IDX_W-1:0]        next_q, next_d;
  logic [IDX_W-1:0]        end_q, end_d;
  logic                    end_known_q, end_known_d;
  logic                    finished_q, finished_d;
  logic [CNT_W-1:0]        held_q, held_d;
  logic [SLOT_W-1:0]       head_q, head_d;
  logic [WINDOW_BYTES-1:0] present_q, present_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic [CNT_W-1:0]        clr_q, clr_d;
  logic                    zero_q, zero_d;
  logic [CNT_W-1:0]        remain_q, remain_d;

  logic                    out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]       out_byte_q, out_byte_d;
  logic                    last_q, last_d;
  logic                    ended_q, ended_d;
  logic [CNT_W-1:0]        count_q, count_d;

  logic [IDX_W-1:0]        off32;
  logic [IDX_W-1:0]        room32;
  logic [SLOT_W-1:0]       off_s;
  logic [SLOT_W-1:0]       ins_slot;
  logic [SLOT_W-1:0]       nb_slot;
  logic [SLOT_W-1:0]       scan_slot;
  logic [SLOT_W-1:0]       clr_slot;
  logic                    pop;
  logic                    in_win;
  logic                    take;
  logic                    store;
  logic                    eos_rec;
  logic                    at0;
  logic                    single;
  logic                    scan_hit;
  logic                    clr_busy;
  logic                    emit;
  logic [BYTE_W-1:0]       rdata;

  // Classification of the item at the head of the queue.
  assign pop      = (state_q == BK_IDLE) && q_valid_i;
  assign q_pop_o  = pop;
  assign off32    = q_item_i.idx - next_q;
  assign room32   = end_q - next_q;
  assign in_win   = (off32 < IDX_W'(WINDOW_BYTES)) && (!end_known_q || (off32 < room32));
  assign off_s    = off32[SLOT_W-1:0];
  assign ins_slot = slot_add(head_q, off_s);
  assign take     = pop && !finished_q && in_win;
  assign store    = take && !present_q[ins_slot];
  assign eos_rec  = take && q_item_i.eos && !end_known_q;
  assign at0      = store && (off_s == '0);
  assign nb_slot  = slot_add(head_q, SLOT_W'(1));
  // A byte landing at the head with no neighbor behind it is a run of one.
  assign single   = at0 && !eos_rec && !present_q[nb_slot];

  // Scan, trim and drain helpers.
  assign scan_slot = slot_add(head_q, scan_q[SLOT_W-1:0]);
  assign scan_hit  = (scan_q < CNT_W'(WINDOW_BYTES)) && present_q[scan_slot];
  assign clr_slot  = slot_add(head_q, clr_q[SLOT_W-1:0]);
  assign clr_busy  = (clr_q < CNT_W'(WINDOW_BYTES));
  assign emit      = (state_q == BK_EMIT) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          if (eos_rec) begin
            state_d = BK_CLEAR;
          end else if (single) begin
            state_d = BK_EMIT;
          end else if (at0) begin
            state_d = BK_SCAN;
          end
        end
      end
      BK_CLEAR: begin
        if (!clr_busy) begin
          state_d = zero_q ? BK_SCAN : BK_IDLE;
        end
      end
      BK_SCAN: begin
        if (!scan_hit) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (emit && (remain_q == CNT_W'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath updates for each state.
  always_comb begin
    next_d      = next_q;
    end_d       = end_q;
    end_known_d = end_known_q;
    finished_d  = finished_q;
    held_d      = held_q;
    head_d      = head_q;
    present_d   = present_q;
    scan_d      = scan_q;
    clr_d       = clr_q;
    zero_d      = zero_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    ended_d     = ended_q;
    count_d     = count_q;
    unique case (state_q)
      BK_IDLE: begin
        if (store) begin
          present_d[ins_slot] = 1'b1;
          held_d              = held_q + 1'b1;
        end
        if (eos_rec) begin
          // Record the end and trim every held byte behind it.
          end_known_d = 1'b1;
          end_d       = q_item_i.idx + 1'b1;
          clr_d       = CNT_W'(off_s) + 1'b1;
          zero_d      = at0;
        end else if (single) begin
          // Stored and delivered at once, so the held count is unchanged.
          held_d     = held_q;
          remain_d   = CNT_W'(1);
          finished_d = end_known_q && (room32 == IDX_W'(1));
        end else if (at0) begin
          scan_d = CNT_W'(1);
        end
      end
      BK_CLEAR: begin
        if (clr_busy) begin
          if (present_q[clr_slot]) begin
            present_d[clr_slot] = 1'b0;
            held_d              = held_q - 1'b1;
          end
          clr_d = clr_q + 1'b1;
        end else if (zero_q) begin
          scan_d = CNT_W'(1);
        end
      end
      BK_SCAN: begin
        if (scan_hit) begin
          scan_d = scan_q + 1'b1;
        end else begin
          // Run length is known: settle the counts that every beat reports.
          remain_d   = scan_q;
          held_d     = held_q - scan_q;
          finished_d = end_known_q && (room32 == IDX_W'(scan_q));
        end
      end
      BK_EMIT: begin
        if (emit) begin
          out_valid_d        = 1'b1;
          out_byte_d         = rdata;
          last_d             = (remain_q == CNT_W'(1));
          ended_d            = finished_q;
          count_d            = held_q;
          present_d[head_q]  = 1'b0;
          head_d             = slot_add(head_q, SLOT_W'(1));
          next_d             = next_q + 1'b1;
          remain_d           = remain_q - 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // Window byte storage; the read address is the next head, so the registered read data matches the head.
  bsr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WINDOW_BYTES)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(ins_slot),
    .wdata_i(q_item_i.data),
    .raddr_i(head_d),
    .rdata_o(rdata)
  );

  // Control and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      next_q      <= '0;
      end_q       <= '0;
      end_known_q <= 1'b0;
      finished_q  <= 1'b0;
      held_q      <= '0;
      head_q      <= '0;
      present_q   <= '0;
      scan_q      <= '0;
      clr_q       <= '0;
      zero_q      <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      end_q       <= end_d;
      end_known_q <= end_known_d;
      finished_q  <= finished_d;
      held_q      <= held_d;
      head_q      <= head_d;
      present_q   <= present_d;
      scan_q      <= scan_d;
      clr_q       <= clr_d;
      zero_q      <= zero_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    ended_q    <= ended_d;
    count_q    <= count_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_byte_o          = out_byte_q;
  assign last_o              = last_q;
  assign stream_ended_o      = ended_q;
  assign unassembled_count_o = COUNT_W'(count_q);

endmodule

### design/byte_stream_reassembler.sv
// Top level of the byte stream reassembler: input queue plus drain engine.
// Depends on bsr_pkg, bsr_front, bsr_back (and bsr_ram below it).
//
//  Channel  Handshake                 Beat contents
//  -------  ------------------------  ------------------------------------------
//  in       in_valid_i / in_stall_o   stream_index_i, data_byte_i, end_of_stream_i
//  out      out_valid_o / out_stall_i out_byte_o, last_o, stream_ended_o,
//                                     unassembled_count_o
//
// A byte that lands at the head of the window with nothing held behind it is
// inserted, then loaded into the output register. A byte that closes a hole and
// completes a run of L bytes is inserted, the run is scanned slot by slot, then
// its beats are delivered in order. An end of stream flag adds a trim pass over
// every window slot behind it. A byte that is dropped or held is handled without
// leaving the idle state. An output stall holds the engine on the pending beat.
// A two-beat input queue absorbs input while output is stalled;
// reset clears all presence bits at once, so no clearing pass is needed.
module byte_stream_reassembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bsr_pkg::IDX_W-1:0]   stream_index_i,
  input  logic [bsr_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        end_of_stream_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bsr_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o,
  output logic                        stream_ended_o,
  output logic [bsr_pkg::COUNT_W-1:0] unassembled_count_o
);
  import bsr_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // Pack the input beat into a queue record.
  assign in_item.idx  = stream_index_i;
  assign in_item.data = data_byte_i;
  assign in_item.eos  = end_of_stream_i;

  bsr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .item_i    (in_item),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  bsr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_byte_o         (out_byte_o),
    .last_o             (last_o),
    .stream_ended_o     (stream_ended_o),
    .unassembled_count_o(unassembled_count_o)
  );

endmodule

### test/tb_byte_stream_reassembler.sv
// Self-checking testbench for the byte stream reassembler top level.
// Needs bsr_pkg and byte_stream_reassembler; a class tracks the reorder window
// and checks every delivered beat in order.
`timescale 1ns / 1ps

module tb_byte_stream_reassembler;
  import bsr_pkg::*;

  // One delivered beat as the window tracker predicts it.
  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               ended;
    logic [COUNT_W-1:0] count;
  } beat_t;

  // Tracks the reorder window and the stream end, and holds the beats still due.
  class stream_tracker;
    logic [BYTE_W-1:0] slot_data [WINDOW_BYTES];
    bit                slot_full [WINDOW_BYTES];
    bit [IDX_W-1:0]    next_idx;
    bit [IDX_W-1:0]    end_idx;
    bit                end_known;
    bit                done;
    int                head;
    int                held;
    int                fails;
    beat_t             due_beats[$];

    function bit at_end();
      return end_known && next_idx == end_idx;
    endfunction

    // Applies one accepted input beat and queues the beats it releases.
    function void take_byte(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] data, logic eos);
      bit [IDX_W-1:0] off;
      int             s;
      beat_t          run[$];
      beat_t          b;
      if (done) return;
      off = idx - next_idx;
      if (off < WINDOW_BYTES && !(end_known && off >= end_idx - next_idx)) begin
        s = (head + int'(off)) % WINDOW_BYTES;
        if (!slot_full[s]) begin
          slot_data[s] = data;
          slot_full[s] = 1'b1;
          held++;
        end
        // A first end flag trims whatever is held beyond it.
        if (eos && !end_known) begin
          end_known = 1'b1;
          end_idx = idx + 1;
          for (int o = int'(off) + 1; o < WINDOW_BYTES; o++) begin
            if (slot_full[(head + o) % WINDOW_BYTES]) begin
              slot_full[(head + o) % WINDOW_BYTES] = 1'b0;
              held--;
            end
          end
        end
      end
      // Drain the contiguous run at the head of the window.
      while (run.size() < WINDOW_BYTES && !at_end() && slot_full[head]) begin
        b.data = slot_data[head];
        slot_full[head] = 1'b0;
        head = (head + 1) % WINDOW_BYTES;
        next_idx++;
        held--;
        run.push_back(b);
      end
      if (at_end()) done = 1'b1;
      foreach (run[i]) begin
        run[i].last  = (i == run.size() - 1);
        run[i].ended = done;
        run[i].count = COUNT_W'(held);
        due_beats.push_back(run[i]);
      end
    endfunction

    // Compares one delivered beat with the oldest one due.
    function void match_beat(logic [BYTE_W-1:0] data, logic last, logic ended,
                             logic [COUNT_W-1:0] count);
      beat_t w;
      if (due_beats.size() == 0) begin
        $error("out beat with nothing due: out_byte %0h", data);
        fails++;
        return;
      end
      w = due_beats.pop_front();
      if (data !== w.data) begin
        $error("out_byte: expected %0h, got %0h", w.data, data);
        fails++;
      end
      if (last !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, last);
        fails++;
      end
      if (ended !== w.ended) begin
        $error("stream_ended: expected %0b, got %0b", w.ended, ended);
        fails++;
      end
      if (count !== w.count) begin
        $error("unassembled_count: expected %0d, got %0d", w.count, count);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [IDX_W-1:0]   stream_index_i;
  logic [BYTE_W-1:0]  data_byte_i;
  logic               end_of_stream_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [BYTE_W-1:0]  out_byte_o;
  logic               last_o;
  logic               stream_ended_o;
  logic [COUNT_W-1:0] unassembled_count_o;

  stream_tracker tracker = new();
  bit            quiet;
  int            beats_sent;

  byte_stream_reassembler uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .stream_index_i      (stream_index_i),
    .data_byte_i         (data_byte_i),
    .end_of_stream_i     (end_of_stream_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_byte_o          (out_byte_o),
    .last_o              (last_o),
    .stream_ended_o      (stream_ended_o),
    .unassembled_count_o (unassembled_count_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every delivered beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.match_beat(out_byte_o, last_o, stream_ended_o, unassembled_count_o);
    end
  end

  // Output stall in random bursts, with the odd long free stretch.
  initial begin
    int burst;
    out_stall_i <= 1'b0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        burst = $urandom_range(1, 8) - 1;
      end else begin
        out_stall_i <= 1'b0;
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8) - 1;
      end
    end
  end

  // Sends one input beat, after an optional idle burst, and notes it once accepted.
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data,
                           input logic eos);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    stream_index_i  <= idx;
    data_byte_i     <= data;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_byte(idx, data, eos);
    beats_sent++;
  endtask

  // Sends offsets 0 .. len-1 above start, shuffled or reversed, with some repeats.
  task automatic send_block(input logic [IDX_W-1:0] start, input int len, input bit reversed);
    int order[];
    int j;
    int tmp;
    order = new[len];
    foreach (order[i]) order[i] = reversed ? len - 1 - i : i;
    if (!reversed) begin
      for (int i = len - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[i]) begin
      send_beat(start + order[i], BYTE_W'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        send_beat(start + order[$urandom_range(0, i)], BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [IDX_W-1:0] base;
    int               kind;
    int               len;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    stream_index_i  <= '0;
    data_byte_i     <= '0;
    end_of_stream_i <= 1'b0;
    quiet = 1'b0;
    beats_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: window edges, drops, duplicates and a small hole.
    send_beat(32'hFFFF_FFFF, 8'hFF, 1'b1);     // far beyond, end flag ignored
    send_beat(32'd64, 8'h81, 1'b1);            // one past the window
    send_beat(32'd63, 8'h00, 1'b0);            // last slot of the window
    send_beat(32'd63, 8'hAA, 1'b0);            // duplicate keeps the first byte
    send_beat(32'd0, 8'h00, 1'b0);
    send_beat(32'd0, 8'h7E, 1'b1);             // below the window, end flag ignored
    send_beat(32'd1, 8'hFF, 1'b0);
    send_beat(32'd5, 8'h55, 1'b0);
    send_beat(32'd3, 8'h33, 1'b0);
    send_beat(32'd4, 8'h44, 1'b0);
    send_beat(32'd2, 8'h22, 1'b0);             // closes the hole, drains four
    send_beat(32'h8000_0000, 8'h5A, 1'b0);
    send_beat(tracker.next_idx + WINDOW_BYTES, 8'hA5, 1'b0);
    send_block(tracker.next_idx, 7, 1'b0);

    // Random: full window first, then mostly shuffled blocks plus noise.
    send_block(tracker.next_idx, WINDOW_BYTES, 1'b1);
    while (beats_sent < 105) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, WINDOW_BYTES)
                                          : $urandom_range(1, 16);
        if (len > 105 - beats_sent) len = 105 - beats_sent;
        send_block(tracker.next_idx, len, 1'b0);
      end else if (kind == 6) begin
        send_beat(tracker.next_idx - $urandom_range(1, 100), BYTE_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (kind == 7) begin
        send_beat(tracker.next_idx + WINDOW_BYTES + $urandom_range(0, 1000),
                  BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind == 8) begin
        send_beat($urandom, BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_beat(tracker.next_idx + $urandom_range(1, WINDOW_BYTES - 1),
                  BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
    end

    // Closing part without idling: end flag with held bytes behind it, then finish.
    quiet = 1'b1;
    base = tracker.next_idx;
    send_beat(base + 10, BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_beat(base + 20, BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_beat(base + 30, BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_beat(base + 63, BYTE_W'($urandom_range(0, 255)), 1'b0);
    send_beat(base + 15, BYTE_W'($urandom_range(0, 255)), 1'b1);  // trims 20, 30, 63
    send_beat(base + 20, BYTE_W'($urandom_range(0, 255)), 1'b1);  // past the known end
    send_beat(base + 15, BYTE_W'($urandom_range(0, 255)), 1'b1);  // duplicate end byte
    send_beat(base + 12, BYTE_W'($urandom_range(0, 255)), 1'b1);  // later end flag ignored
    send_block(base, 16, 1'b0);
    // The stream has ended, so these are ignored.
    send_beat(base + 16, 8'h11, 1'b0);
    send_beat(tracker.next_idx, 8'h22, 1'b1);
    send_beat($urandom, 8'h33, 1'b0);
    in_valid_i <= 1'b0;

    while (tracker.due_beats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (tracker.due_beats.size() != 0) begin
      $error("%0d beats never delivered", tracker.due_beats.size());
      tracker.fails++;
    end
    if (tracker.fails == 0) begin
      $display("[byte_stream_reassembler] OK");
    end else begin
      $display("[byte_stream_reassembler] ERROR");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #1_000_000;
    $display("[byte_stream_reassembler] ERROR");
    $finish;
  end

endmodule

### byte_stream_reassembler.f
design/bsr_pkg.sv
design/bsr_ram.sv
design/bsr_front.sv
design/bsr_back.sv
design/byte_stream_reassembler.sv
test/tb_byte_stream_reassembler.sv
